FILE: sv/assert_macros.svh
// assertion macros shared by the fixup unit rtl
// no dependencies; included by modules that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge, masked while reset is held
`define FUTF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// same check with reset not masked
`define FUTF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: sv/futf_pkg.sv
// shared types, opcodes and cause codes for the fpu unimplemented trap fixup unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package futf_pkg;

    // major opcodes, instruction bits 31..26
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_COP1    = 6'h11;
    localparam logic [5:0] OP_COP1X   = 6'h13;
    localparam logic [5:0] OP_LWC1    = 6'h31;
    localparam logic [5:0] OP_LDC1    = 6'h35;
    localparam logic [5:0] OP_SWC1    = 6'h39;
    localparam logic [5:0] OP_SDC1    = 6'h3d;

    // cop1x function codes, instruction bits 5..0
    localparam logic [5:0] FN_MADD_S  = 6'h20;
    localparam logic [5:0] FN_NMADD_S = 6'h30;
    localparam logic [5:0] FN_MSUB_S  = 6'h28;
    localparam logic [5:0] FN_NMSUB_S = 6'h38;
    localparam logic [5:0] FN_MADD_D  = 6'h21;
    localparam logic [5:0] FN_MSUB_D  = 6'h29;
    localparam logic [5:0] FN_NMADD_D = 6'h31;
    localparam logic [5:0] FN_NMSUB_D = 6'h39;
    localparam logic [5:0] FN_LWXC1   = 6'h00;
    localparam logic [5:0] FN_LDXC1   = 6'h01;
    localparam logic [5:0] FN_SWXC1   = 6'h08;
    localparam logic [5:0] FN_SDXC1   = 6'h09;
    localparam logic [5:0] FN_PREFX   = 6'h0f;

    localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
    localparam logic [8:0]  EXP_BIAS = 9'd127;
    localparam logic [31:0] PC_STEP  = 32'd4;

    typedef enum logic [4:0] {
        CAUSE_SPECIAL     = 5'd0,
        CAUSE_COP1        = 5'd1,
        CAUSE_MADD_S      = 5'd2,
        CAUSE_NMADD_S     = 5'd3,
        CAUSE_MSUB_S      = 5'd4,
        CAUSE_NMSUB_S     = 5'd5,
        CAUSE_MADD_D      = 5'd6,
        CAUSE_MSUB_D      = 5'd7,
        CAUSE_NMADD_D     = 5'd8,
        CAUSE_NMSUB_D     = 5'd9,
        CAUSE_LWXC1       = 5'd10,
        CAUSE_LDXC1       = 5'd11,
        CAUSE_SWXC1       = 5'd12,
        CAUSE_SDXC1       = 5'd13,
        CAUSE_PREFX       = 5'd14,
        CAUSE_COP1X_OTHER = 5'd15,
        CAUSE_LWC1        = 5'd16,
        CAUSE_LDC1        = 5'd17,
        CAUSE_SWC1        = 5'd18,
        CAUSE_SDC1        = 5'd19,
        CAUSE_NOT_FPU     = 5'd20
    } t_cause;

    typedef struct packed {
        logic [31:0] instruction;
        logic [31:0] trap_pc;
        logic [31:0] ft_value;
        logic [31:0] fs_value;
        logic [31:0] fr_value;
    } t_in_word;

    typedef struct packed {
        logic        fixed;
        logic [4:0]  dest_index;
        logic [31:0] dest_value;
        logic [31:0] next_pc;
        t_cause      cause;
    } t_out_word;

endpackage

`default_nettype wire

FILE: sv/futf_if.sv
// valid/ready channel interfaces for the trap fixup unit
// depends on futf_pkg for the word types
`timescale 1ns / 1ps
`default_nettype none

interface futf_in_if;
    logic               valid;
    logic               ready;
    futf_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface futf_out_if;
    logic                valid;
    logic                ready;
    futf_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/futf_core.sv
// combinational decode and underflow fixup for one trapping instruction
// depends on futf_pkg
`timescale 1ns / 1ps
`default_nettype none

module futf_core (
    input  wire futf_pkg::t_in_word i_word,
    output futf_pkg::t_out_word     o_word
);

    logic [5:0]       w_opcode;
    logic [5:0]       w_funct;
    futf_pkg::t_cause w_cause;
    logic [8:0]       w_exp_sum;
    logic             w_single_fma;
    logic             w_underflow;
    logic             w_negate;

    assign w_opcode = i_word.instruction[31:26];
    assign w_funct  = i_word.instruction[5:0];

    always_comb begin
        w_cause = futf_pkg::CAUSE_NOT_FPU;
        unique case (w_opcode)
            futf_pkg::OP_SPECIAL: w_cause = futf_pkg::CAUSE_SPECIAL;
            futf_pkg::OP_COP1:    w_cause = futf_pkg::CAUSE_COP1;
            futf_pkg::OP_COP1X: begin
                unique case (w_funct)
                    futf_pkg::FN_MADD_S:  w_cause = futf_pkg::CAUSE_MADD_S;
                    futf_pkg::FN_NMADD_S: w_cause = futf_pkg::CAUSE_NMADD_S;
                    futf_pkg::FN_MSUB_S:  w_cause = futf_pkg::CAUSE_MSUB_S;
                    futf_pkg::FN_NMSUB_S: w_cause = futf_pkg::CAUSE_NMSUB_S;
                    futf_pkg::FN_MADD_D:  w_cause = futf_pkg::CAUSE_MADD_D;
                    futf_pkg::FN_MSUB_D:  w_cause = futf_pkg::CAUSE_MSUB_D;
                    futf_pkg::FN_NMADD_D: w_cause = futf_pkg::CAUSE_NMADD_D;
                    futf_pkg::FN_NMSUB_D: w_cause = futf_pkg::CAUSE_NMSUB_D;
                    futf_pkg::FN_LWXC1:   w_cause = futf_pkg::CAUSE_LWXC1;
                    futf_pkg::FN_LDXC1:   w_cause = futf_pkg::CAUSE_LDXC1;
                    futf_pkg::FN_SWXC1:   w_cause = futf_pkg::CAUSE_SWXC1;
                    futf_pkg::FN_SDXC1:   w_cause = futf_pkg::CAUSE_SDXC1;
                    futf_pkg::FN_PREFX:   w_cause = futf_pkg::CAUSE_PREFX;
                    default:              w_cause = futf_pkg::CAUSE_COP1X_OTHER;
                endcase
            end
            futf_pkg::OP_LWC1:    w_cause = futf_pkg::CAUSE_LWC1;
            futf_pkg::OP_LDC1:    w_cause = futf_pkg::CAUSE_LDC1;
            futf_pkg::OP_SWC1:    w_cause = futf_pkg::CAUSE_SWC1;
            futf_pkg::OP_SDC1:    w_cause = futf_pkg::CAUSE_SDC1;
            default:              w_cause = futf_pkg::CAUSE_NOT_FPU;
        endcase
    end

    // biased exponents summed; product underflows when the sum stays at or below the bias
    assign w_exp_sum = {1'b0, i_word.ft_value[30:23]} + {1'b0, i_word.fs_value[30:23]};

    assign w_single_fma = (w_cause == futf_pkg::CAUSE_MADD_S)
                       || (w_cause == futf_pkg::CAUSE_NMADD_S)
                       || (w_cause == futf_pkg::CAUSE_MSUB_S)
                       || (w_cause == futf_pkg::CAUSE_NMSUB_S);
    assign w_underflow  = w_single_fma && (w_exp_sum <= futf_pkg::EXP_BIAS);
    assign w_negate     = (w_cause == futf_pkg::CAUSE_NMADD_S)
                       || (w_cause == futf_pkg::CAUSE_MSUB_S);

    always_comb begin
        o_word.fixed      = w_underflow;
        o_word.cause      = w_cause;
        o_word.dest_index = '0;
        o_word.dest_value = '0;
        o_word.next_pc    = i_word.trap_pc;
        if (w_underflow) begin
            o_word.dest_index = i_word.instruction[10:6];
            o_word.dest_value = w_negate ? (i_word.fr_value ^ futf_pkg::SIGN_BIT)
                                         : i_word.fr_value;
            o_word.next_pc    = i_word.trap_pc + futf_pkg::PC_STEP;
        end
    end

endmodule

`default_nettype wire

FILE: sv/fpu_unimplemented_trap_fixup_unit.sv
// fpu unimplemented-operation trap fixup unit, top level
// depends on futf_pkg, futf_if, futf_core and assert_macros.svh
//
// usage:
//   i_in  carries one trapping word: instruction, trap pc and the ft, fs, fr
//         operand bits. a word is taken on an edge where valid and ready are high.
//   o_out carries one result word per input word: fixed flag, fd index, fd value,
//         resume pc and the cause code, in input order.
//   single-precision madd/msub/nmadd/nmsub whose exponent sum underflows are
//   fixed up (fd gets fr, negated for nmadd and msub, pc advances by 4);
//   everything else is reported with its cause code and the pc unchanged.
// timing:
//   an accepted word passes through the input register, the decode and exponent
//   test in futf_core, then the result register. throughput is one word per cycle
//   while o_out.ready is high, set by the single pass through futf_core.
// reset and stalls:
//   synchronous active-low reset empties both registers; nothing is pending after.
//   i_in.ready stays low while reset is held.
//   when the receiver holds ready low the result word stays put and the input
//   register still fills, so up to two words sit in the unit before i_in.ready drops.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fpu_unimplemented_trap_fixup_unit (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    futf_in_if.sink      i_in,
    futf_out_if.source   o_out
);

    // input register
    logic                r_s1_valid;
    futf_pkg::t_in_word  r_s1_word;
    // result register
    logic                r_out_valid;
    futf_pkg::t_out_word r_out_word;

    futf_pkg::t_out_word w_result;
    logic                w_out_free;
    logic                w_s1_move;
    logic                w_in_take;
    logic                n_s1_valid;
    logic                n_out_valid;

    futf_core u_core (
        .i_word (r_s1_word),
        .o_word (w_result)
    );

    // result slot frees up when empty or being drained this cycle
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_s1_move   = r_s1_valid && w_out_free;
    assign i_in.ready  = i_rst_n && (!r_s1_valid || w_out_free);
    assign w_in_take   = i_in.valid && i_in.ready;

    assign n_s1_valid  = w_in_take || (r_s1_valid && !w_out_free);
    assign n_out_valid = w_s1_move || (r_out_valid && !o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_s1_word <= i_in.data;
        end
        if (w_s1_move) begin
            r_out_word <= w_result;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_word;

    // checks
    `FUTF_ASSERT(a_fix_only_single_fma,
        (r_out_valid && r_out_word.fixed) |->
            (r_out_word.cause == futf_pkg::CAUSE_MADD_S
             || r_out_word.cause == futf_pkg::CAUSE_NMADD_S
             || r_out_word.cause == futf_pkg::CAUSE_MSUB_S
             || r_out_word.cause == futf_pkg::CAUSE_NMSUB_S),
        "fixup applied to an instruction that is not a single fused op")
    `FUTF_ASSERT(a_trap_clears_dest,
        (r_out_valid && !r_out_word.fixed) |->
            (r_out_word.dest_index == 5'd0 && r_out_word.dest_value == 32'd0),
        "reported trap carries a destination")
    `FUTF_ASSERT(a_fixed_pc_advances,
        (w_s1_move && w_result.fixed) |=>
            (r_out_word.next_pc == $past(r_s1_word.trap_pc) + futf_pkg::PC_STEP),
        "fixed result does not resume at pc plus four")
    `FUTF_ASSERT(a_take_fills_s1,
        w_in_take |=> r_s1_valid,
        "accepted word did not land in the input register")

endmodule

`default_nettype wire
